/* rtl/core/mexp_pkg.sv */
// Shared types and constants for the modular exponentiation core.
// Used by mexp_ctrl, mexp_dp, modular_exponentiation_core and the testbench; no dependencies.
`timescale 1ns / 1ps

package mexp_pkg;

	localparam int WIDTH = 32;
	localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
	localparam int IN_W  = ((3 * WIDTH + 7) / 8) * 8;
	localparam int OUT_W = ((WIDTH + 1 + 7) / 8) * 8;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_REDUCE,
		ST_SQ_START,
		ST_SQUARE,
		ST_BM_START,
		ST_MULT,
		ST_NEXT_BIT,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;         // capture operands, begin base reduction
		logic step;         // one shift-add-reduce step
		logic commit_base;  // write step result to reduced base
		logic commit_v;     // write step result to running value
		logic sq_start;     // set up v * v
		logic bm_start;     // set up v * base
		logic exp_shift;    // advance to next exponent bit
		logic emit;         // write result register
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic step_last;
		logic exp_last;
		logic exp_bit;
		logic mod_zero;
		logic exp_zero;
	} dp_status_t;

endpackage

/* rtl/core/mexp_dp.sv */
// Datapath of the modular exponentiation core: operand registers and a
// shared shift-add-reduce unit. Depends on mexp_pkg.
`timescale 1ns / 1ps

module mexp_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mexp_pkg::dp_cmd_t        cmd,
	output mexp_pkg::dp_status_t     status,
	input  logic [mexp_pkg::WIDTH-1:0] in_base,
	input  logic [mexp_pkg::WIDTH-1:0] in_exponent,
	input  logic [mexp_pkg::WIDTH-1:0] in_modulus,
	output logic [mexp_pkg::WIDTH-1:0] power_mod,
	output logic                     modulus_error
);

	localparam int W = mexp_pkg::WIDTH;
	localparam int CW = mexp_pkg::CNT_W;

	logic [W-1:0]  base_q, exp_q, mod_q, v_q, r_q, a_q, b_q;
	logic [CW-1:0] cnt_q, ecnt_q;
	logic          red_q, mod_zero_q, exp_zero_q;
	logic [W-1:0]  res_q;
	logic          err_q;

	logic          b_msb;
	logic [W-1:0]  addend;
	logic [W+2:0]  t, d1, d2;
	logic [W-1:0]  r_next;

	// r_next = (2r + addend) mod m; the sum stays below 3m
	always_comb begin
		b_msb = b_q[W-1];
		if (red_q) begin
			addend = {{(W-1){1'b0}}, b_msb};
		end else begin
			addend = b_msb ? a_q : '0;
		end
		t  = {2'b00, r_q, 1'b0} + {3'b000, addend};
		d1 = t - {3'b000, mod_q};
		d2 = t - {2'b00, mod_q, 1'b0};
		if (!d2[W+2]) begin
			r_next = d2[W-1:0];
		end else if (!d1[W+2]) begin
			r_next = d1[W-1:0];
		end else begin
			r_next = t[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q      <= 1'b0;
			mod_zero_q <= 1'b0;
			exp_zero_q <= 1'b0;
			cnt_q      <= '0;
			ecnt_q     <= '0;
		end else begin
			if (cmd.load) begin
				red_q      <= 1'b1;
				mod_zero_q <= (in_modulus == '0);
				exp_zero_q <= (in_exponent == '0);
				cnt_q      <= CW'(W - 1);
				ecnt_q     <= CW'(W - 1);
			end else if (cmd.sq_start || cmd.bm_start) begin
				red_q <= 1'b0;
				cnt_q <= CW'(W - 1);
			end else if (cmd.step) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.exp_shift) begin
				ecnt_q <= ecnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q <= in_base;
			exp_q  <= in_exponent;
			mod_q  <= in_modulus;
			v_q    <= (in_modulus == W'(1)) ? '0 : W'(1);
			r_q    <= '0;
			a_q    <= '0;
			b_q    <= in_base;
		end else if (cmd.sq_start) begin
			r_q <= '0;
			a_q <= v_q;
			b_q <= v_q;
		end else if (cmd.bm_start) begin
			r_q <= '0;
			a_q <= base_q;
			b_q <= v_q;
		end else if (cmd.step) begin
			r_q <= r_next;
			b_q <= {b_q[W-2:0], 1'b0};
		end
		if (cmd.commit_base) begin
			base_q <= r_next;
		end
		if (cmd.commit_v) begin
			v_q <= r_next;
		end
		if (cmd.exp_shift) begin
			exp_q <= {exp_q[W-2:0], 1'b0};
		end
		if (cmd.emit) begin
			err_q <= mod_zero_q;
			if (mod_zero_q) begin
				res_q <= '0;
			end else if (exp_zero_q) begin
				res_q <= W'(1);
			end else begin
				res_q <= v_q;
			end
		end
	end

	always_comb begin
		status.step_last = (cnt_q == '0);
		status.exp_last  = (ecnt_q == '0);
		status.exp_bit   = exp_q[W-1];
		status.mod_zero  = mod_zero_q;
		status.exp_zero  = exp_zero_q;
	end

	assign power_mod     = res_q;
	assign modulus_error = err_q;

endmodule

/* rtl/core/mexp_ctrl.sv */
// Controller of the modular exponentiation core: sequences reduction,
// squarings and multiplications, and owns the handshakes. Depends on mexp_pkg.
`timescale 1ns / 1ps

module mexp_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	output mexp_pkg::dp_cmd_t      cmd,
	input  mexp_pkg::dp_status_t   status
);

	mexp_pkg::state_t state_q, state_d;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mexp_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			mexp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = mexp_pkg::ST_CHECK;
				end
			end
			mexp_pkg::ST_CHECK: begin
				if (status.mod_zero || status.exp_zero) begin
					state_d = mexp_pkg::ST_FINISH;
				end else begin
					state_d = mexp_pkg::ST_REDUCE;
				end
			end
			mexp_pkg::ST_REDUCE: begin
				cmd.step = 1'b1;
				if (status.step_last) begin
					cmd.commit_base = 1'b1;
					state_d         = mexp_pkg::ST_SQ_START;
				end
			end
			mexp_pkg::ST_SQ_START: begin
				cmd.sq_start = 1'b1;
				state_d      = mexp_pkg::ST_SQUARE;
			end
			mexp_pkg::ST_SQUARE: begin
				cmd.step = 1'b1;
				if (status.step_last) begin
					cmd.commit_v = 1'b1;
					state_d = status.exp_bit ? mexp_pkg::ST_BM_START : mexp_pkg::ST_NEXT_BIT;
				end
			end
			mexp_pkg::ST_BM_START: begin
				cmd.bm_start = 1'b1;
				state_d      = mexp_pkg::ST_MULT;
			end
			mexp_pkg::ST_MULT: begin
				cmd.step = 1'b1;
				if (status.step_last) begin
					cmd.commit_v = 1'b1;
					state_d      = mexp_pkg::ST_NEXT_BIT;
				end
			end
			mexp_pkg::ST_NEXT_BIT: begin
				cmd.exp_shift = 1'b1;
				state_d = status.exp_last ? mexp_pkg::ST_FINISH : mexp_pkg::ST_SQ_START;
			end
			mexp_pkg::ST_FINISH: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = mexp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mexp_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

/* rtl/core/modular_exponentiation_core.sv */
// Modular exponentiation core: base^exponent mod modulus by square-and-multiply.
// A zero modulus or zero exponent goes straight to the result; otherwise one squaring
// per exponent bit and one multiplication per set exponent bit follow the base reduction.
// Throughput: one transaction at a time; the rate is set by the shared
// shift-add-reduce unit, one multiplier bit per cycle.
// Reset: arst_n clears the controller, the output valid and the datapath flags and counters; no clearing pass.
`timescale 1ns / 1ps

module modular_exponentiation_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [mexp_pkg::IN_W-1:0]   s_tdata,  // base, exponent, modulus
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [mexp_pkg::OUT_W-1:0]  m_tdata   // power_mod, modulus_error, zero fill
);

	localparam int W = mexp_pkg::WIDTH;

	mexp_pkg::dp_cmd_t    cmd;
	mexp_pkg::dp_status_t status;
	logic [W-1:0]         power_mod;
	logic                 modulus_error;

	mexp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.status    (status)
	);

	mexp_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.in_base       (s_tdata[W-1:0]),
		.in_exponent   (s_tdata[2*W-1:W]),
		.in_modulus    (s_tdata[3*W-1:2*W]),
		.power_mod     (power_mod),
		.modulus_error (modulus_error)
	);

	assign m_tdata = {{(mexp_pkg::OUT_W - W - 1){1'b0}}, modulus_error, power_mod};

endmodule

/* test/modular_exponentiation_core_tb.sv */
// Self-checking bench for modular_exponentiation_core: directed table, then random mix.
// Depends on mexp_pkg and the core; results come from the row or a local square-and-multiply model.
`timescale 1ns / 1ps

module modular_exponentiation_core_tb;

	localparam int    WIDTH       = mexp_pkg::WIDTH;
	localparam int    IN_W        = mexp_pkg::IN_W;
	localparam int    OUT_W       = mexp_pkg::OUT_W;
	localparam int    N_DIRECTED  = 22;
	localparam int    N_RANDOM    = 270;
	localparam int    CALM_ITEMS  = 30;
	localparam int    PRESSURE_AT = 30;
	localparam int    PRESSURE_CY = 4000;
	localparam int    DRAIN_CY    = 2200;
	localparam int    CYCLE_LIMIT = 3_000_000;

	typedef logic [WIDTH-1:0] word_t;

	typedef struct {
		word_t base;
		word_t exponent;
		word_t modulus;
		bit    fixed_ref;  // expected result given in the row itself
		word_t ref_pm;
		bit    ref_err;
	} request_t;

	typedef struct {
		word_t power_mod;
		bit    modulus_error;
	} pm_result_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;   // base, exponent, modulus
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;   // power_mod, modulus_error, zero fill

	request_t   stim_items[$];
	pm_result_t pending_results[$];
	int         mismatch_count;
	int         results_seen;
	bit         stim_done;
	bit         calm;
	bit         pressure_done;

	// base, exponent, modulus, fixed, power_mod, modulus_error
	request_t directed_rows [N_DIRECTED] = '{
		'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1, 32'h0, 1},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1, 32'h0, 1},
		'{32'h0000_0005, 32'h0000_0000, 32'h0000_0007, 1, 32'h1, 0},
		'{32'h0000_007B, 32'h0000_0000, 32'h0000_0001, 1, 32'h1, 0},
		'{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1, 32'h1, 0},
		'{32'h0000_0000, 32'h0000_0000, 32'h0000_0005, 1, 32'h1, 0},
		'{32'h0000_0007, 32'h0000_0005, 32'h0000_0001, 1, 32'h0, 0},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1, 32'h0, 0},
		'{32'h0000_0000, 32'h0000_0001, 32'h0000_000D, 1, 32'h0, 0},
		'{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0, 0},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0, 0},
		'{32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFB, 1, 32'h1, 0},
		'{32'h0000_0002, 32'h0000_000A, 32'h0000_03E8, 0, 32'h0, 0},
		'{32'h0000_0003, 32'h0000_0001, 32'h0000_0007, 0, 32'h0, 0},
		'{32'h0000_000A, 32'h0000_0001, 32'h0000_0007, 0, 32'h0, 0},
		'{32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'h0, 0},
		'{32'hFFFF_FFFF, 32'h0000_0002, 32'hFFFF_FFFB, 0, 32'h0, 0},
		'{32'h1234_5678, 32'h8000_0000, 32'h8765_4321, 0, 32'h0, 0},
		'{32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 0, 32'h0, 0},
		'{32'h0000_0002, 32'h0000_001F, 32'hFFFF_FFFF, 0, 32'h0, 0},
		'{32'h0000_0005, 32'h0000_0003, 32'h0000_0002, 0, 32'h0, 0},
		'{32'h0000_0002, 32'h0000_0020, 32'hFFFF_FFFF, 0, 32'h0, 0}
	};

	modular_exponentiation_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Square-and-multiply from the top exponent bit, products at double width
	function automatic pm_result_t predict_power_mod(word_t b, word_t e, word_t m);
		pm_result_t      r;
		logic [2*WIDTH-1:0] acc;
		logic [2*WIDTH-1:0] b_red;
		r.modulus_error = 1'b0;
		r.power_mod     = '0;
		if (m == '0) begin
			r.modulus_error = 1'b1;
		end else if (e == '0) begin
			r.power_mod = 1;
		end else begin
			b_red = {{WIDTH{1'b0}}, b} % {{WIDTH{1'b0}}, m};
			acc   = 1 % {{WIDTH{1'b0}}, m};
			for (int i = WIDTH - 1; i >= 0; i--) begin
				acc = (acc * acc) % {{WIDTH{1'b0}}, m};
				if (e[i])
					acc = (acc * b_red) % {{WIDTH{1'b0}}, m};
			end
			r.power_mod = acc[WIDTH-1:0];
		end
		return r;
	endfunction

	function automatic word_t pick_word(bit is_modulus);
		word_t w;
		w = $urandom();
		case ($urandom_range(0, 9))
			0: w = is_modulus ? word_t'(0) : word_t'($urandom_range(0, 3));
			1: w = is_modulus ? word_t'(1) : '1;
			2: w = word_t'($urandom_range(2, 255));
			3: w = '1 - word_t'($urandom_range(0, 255));
			default: ;
		endcase
		return w;
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		request_t rq;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		calm     = 1'b0;
		for (int i = 0; i < N_DIRECTED; i++)
			stim_items.push_back(directed_rows[i]);
		for (int i = 0; i < N_RANDOM; i++) begin
			rq.base      = pick_word(1'b0);
			rq.modulus   = pick_word(1'b1);
			rq.fixed_ref = 1'b0;
			rq.ref_pm    = '0;
			rq.ref_err   = 1'b0;
			case ($urandom_range(0, 9))
				0: rq.exponent = '0;
				1, 2: rq.exponent = word_t'($urandom_range(1, 16));
				3: rq.exponent = '1;
				default: rq.exponent = $urandom();
			endcase
			stim_items.push_back(rq);
		end
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
	end

	// Sender: offer each item, with random gaps until the calm tail
	initial begin
		request_t   rq;
		pm_result_t pr;
		stim_done = 1'b0;
		wait (arst_n);
		@(negedge clk);
		for (int i = 0; i < stim_items.size(); i++) begin
			rq = stim_items[i];
			if (i >= stim_items.size() - CALM_ITEMS)
				calm = 1'b1;
			if (!calm && $urandom_range(0, 2) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= IN_W'({rq.modulus, rq.exponent, rq.base});
			@(posedge clk);
			while (!s_tready)
				@(posedge clk);
			if (rq.fixed_ref) begin
				pr.power_mod     = rq.ref_pm;
				pr.modulus_error = rq.ref_err;
			end else begin
				pr = predict_power_mod(rq.base, rq.exponent, rq.modulus);
			end
			pending_results.push_back(pr);
			@(negedge clk);
		end
		s_tvalid <= 1'b0;
		stim_done = 1'b1;
	end

	// Receiver: random stalls, plus one long hold so the core backs up its input
	initial begin
		int hold;
		hold          = 0;
		pressure_done = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (results_seen == PRESSURE_AT && !pressure_done) begin
				pressure_done = 1'b1;
				hold          = PRESSURE_CY;
			end else if (hold == 0 && !calm && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(1, 18);
			end
			if (hold > 0) begin
				m_tready <= 1'b0;
				hold--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		pm_result_t pr;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen = results_seen + 1;
			if (pending_results.size() == 0) begin
				$error("unexpected result: power_mod %h modulus_error %b",
					m_tdata[WIDTH-1:0], m_tdata[WIDTH]);
				mismatch_count = mismatch_count + 1;
			end else begin
				pr = pending_results.pop_front();
				if (m_tdata[WIDTH-1:0] !== pr.power_mod) begin
					$error("power_mod: expected %h, actual %h", pr.power_mod,
						m_tdata[WIDTH-1:0]);
					mismatch_count = mismatch_count + 1;
				end
				if (m_tdata[WIDTH] !== pr.modulus_error) begin
					$error("modulus_error: expected %b, actual %b", pr.modulus_error,
						m_tdata[WIDTH]);
					mismatch_count = mismatch_count + 1;
				end
			end
		end
	end

	initial begin
		mismatch_count = 0;
		results_seen   = 0;
		wait (arst_n);
		wait (stim_done);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CY) @(posedge clk);
		if (pending_results.size() != 0)
			$error("%0d expected results never arrived", pending_results.size());
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$error("timeout after %0d cycles", CYCLE_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

endmodule
